@@ rtl/core/vsdtg_pkg.sv @@
// Package for the video sync / DE timing generator.
// Holds register widths, reset values, register indexes and the axis status type.
// No dependencies.
`default_nettype none

package vsdtg_pkg;

  localparam int REG_W             = 12;
  localparam int CFG_IDX_W         = 3;
  localparam int COUNTER_WIDTH_DEF = 12;

  localparam logic [REG_W-1:0] H_TOTAL_RST         = 12'd264;
  localparam logic [REG_W-1:0] H_SYNC_WIDTH_RST    = 12'd32;
  localparam logic [REG_W-1:0] H_VISIBLE_START_RST = 12'd64;
  localparam logic [REG_W-1:0] V_TOTAL_RST         = 12'd628;
  localparam logic [REG_W-1:0] V_SYNC_WIDTH_RST    = 12'd2;
  localparam logic [REG_W-1:0] V_VISIBLE_START_RST = 12'd28;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_H_TOTAL         = 3'd0,
    REG_H_SYNC_WIDTH    = 3'd1,
    REG_H_VISIBLE_START = 3'd2,
    REG_V_TOTAL         = 3'd3,
    REG_V_SYNC_WIDTH    = 3'd4,
    REG_V_VISIBLE_START = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic wrap;
    logic at_zero;
    logic sync_level;
    logic visible;
  } axis_status_t;

endpackage

`default_nettype wire

@@ rtl/core/vsdtg_axis_counter.sv @@
// One timing axis: position counter with wrap at its total, plus sync and visible decode.
// Depends on vsdtg_pkg.
`default_nettype none

module vsdtg_axis_counter
  import vsdtg_pkg::*;
#(
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             advance_i,
  input  wire logic [REG_W-1:0] total_i,
  input  wire logic [REG_W-1:0] sync_width_i,
  input  wire logic [REG_W-1:0] visible_start_i,
  output axis_status_t          status_o
);

  localparam int CmpW = ((COUNTER_WIDTH > REG_W) ? COUNTER_WIDTH : REG_W) + 1;

  logic [COUNTER_WIDTH-1:0] cnt_r;
  logic [COUNTER_WIDTH-1:0] cnt_nxt;
  logic [CmpW-1:0]          cnt_ext;
  logic [CmpW-1:0]          cnt_inc;
  logic                     wrap;

  assign cnt_ext = CmpW'(cnt_r);
  assign cnt_inc = cnt_ext + CmpW'(1);
  assign wrap    = (cnt_inc >= CmpW'(total_i)) || (&cnt_r);

  always_comb begin
    cnt_nxt = cnt_r;
    if (advance_i) begin
      cnt_nxt = wrap ? '0 : cnt_inc[COUNTER_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign status_o.wrap       = wrap;
  assign status_o.at_zero    = (cnt_r == '0);
  assign status_o.sync_level = !(cnt_ext < CmpW'(sync_width_i));
  assign status_o.visible    = (cnt_ext >= CmpW'(visible_start_i));

endmodule

`default_nettype wire

@@ rtl/core/video_sync_de_timing_generator_top.sv @@
// Top level of the video sync / DE timing generator: config registers, two axis counters
// and the result register. Depends on vsdtg_pkg and vsdtg_axis_counter.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid / in_stall  in_pixel_enable
//   out      output     out_valid / out_stall out_hsync_level, out_vsync_level,
//                                            out_data_enable, out_frame_start
//   cfg      input      cfg_we               cfg_index, cfg_wdata
//
// Each request gives its result in the cycle after acceptance, and one request can be taken
// every cycle while in_stall is low; the result register is the only stage.
// On an accepted request with pixel_enable set the h counter advances, and v if h wraps.
// in_stall is high only while a result waits in the register and out_stall is high.
// Synchronous reset clears the counters and the result valid, and restores the registers.
`default_nettype none

module video_sync_de_timing_generator_top
  import vsdtg_pkg::*;
#(
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_pixel_enable,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_hsync_level,
  output logic                      out_vsync_level,
  output logic                      out_data_enable,
  output logic                      out_frame_start,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [REG_W-1:0]     cfg_wdata
);

  logic [REG_W-1:0] h_total_r, h_sync_width_r, h_visible_start_r;
  logic [REG_W-1:0] v_total_r, v_sync_width_r, v_visible_start_r;

  logic         accept;
  logic         h_adv;
  logic         v_adv;
  axis_status_t h_stat;
  axis_status_t v_stat;

  logic out_valid_r, out_valid_nxt;
  logic hsync_r, vsync_r, de_r, fs_r;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign h_adv    = accept && in_pixel_enable;
  assign v_adv    = h_adv && h_stat.wrap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_total_r         <= H_TOTAL_RST;
      h_sync_width_r    <= H_SYNC_WIDTH_RST;
      h_visible_start_r <= H_VISIBLE_START_RST;
      v_total_r         <= V_TOTAL_RST;
      v_sync_width_r    <= V_SYNC_WIDTH_RST;
      v_visible_start_r <= V_VISIBLE_START_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_H_TOTAL:         h_total_r         <= cfg_wdata;
        REG_H_SYNC_WIDTH:    h_sync_width_r    <= cfg_wdata;
        REG_H_VISIBLE_START: h_visible_start_r <= cfg_wdata;
        REG_V_TOTAL:         v_total_r         <= cfg_wdata;
        REG_V_SYNC_WIDTH:    v_sync_width_r    <= cfg_wdata;
        REG_V_VISIBLE_START: v_visible_start_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  vsdtg_axis_counter #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_h_axis (
    .clk            (clk),
    .rst_n          (rst_n),
    .advance_i      (h_adv),
    .total_i        (h_total_r),
    .sync_width_i   (h_sync_width_r),
    .visible_start_i(h_visible_start_r),
    .status_o       (h_stat)
  );

  vsdtg_axis_counter #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_v_axis (
    .clk            (clk),
    .rst_n          (rst_n),
    .advance_i      (v_adv),
    .total_i        (v_total_r),
    .sync_width_i   (v_sync_width_r),
    .visible_start_i(v_visible_start_r),
    .status_o       (v_stat)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hsync_r <= h_stat.sync_level;
      vsync_r <= v_stat.sync_level;
      de_r    <= h_stat.visible && v_stat.visible;
      fs_r    <= h_stat.at_zero && v_stat.at_zero;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hsync_level = hsync_r;
  assign out_vsync_level = vsync_r;
  assign out_data_enable = de_r;
  assign out_frame_start = fs_r;

endmodule

`default_nettype wire
